// ===== rtl/core/lbc_pkg.sv =====
// lbc_pkg: shared types and codes for the lru ttl byte budget cache
// no dependencies; compiled first
`timescale 1ns / 1ps

package lbc_pkg;

   localparam logic [1:0] CMD_GET   = 2'd0;
   localparam logic [1:0] CMD_PUT   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] REG_ENTRY_LIMIT  = 2'd0;
   localparam logic [1:0] REG_BYTE_BUDGET  = 2'd1;
   localparam logic [1:0] REG_TIME_TO_LIVE = 2'd2;

   localparam logic [7:0]  ENTRY_LIMIT_RESET  = 8'd100;
   localparam logic [31:0] BYTE_BUDGET_RESET  = 32'd8388608;
   localparam logic [31:0] TIME_TO_LIVE_RESET = 32'd60;

   localparam logic [4:0] DP_NONE   = 5'd0;
   localparam logic [4:0] DP_LOAD   = 5'd1;
   localparam logic [4:0] DP_CLEAR  = 5'd2;
   localparam logic [4:0] DP_FIND   = 5'd3;
   localparam logic [4:0] DP_EXPIRE = 5'd4;
   localparam logic [4:0] DP_LRU    = 5'd5;
   localparam logic [4:0] DP_LDROP  = 5'd6;
   localparam logic [4:0] DP_DROP   = 5'd7;
   localparam logic [4:0] DP_TOUCH  = 5'd8;
   localparam logic [4:0] DP_INSERT = 5'd9;
   localparam logic [4:0] DP_RRD    = 5'd10;
   localparam logic [4:0] DP_RHOLD  = 5'd11;
   localparam logic [4:0] DP_RSCAN  = 5'd12;
   localparam logic [4:0] DP_RWR    = 5'd13;
   localparam logic [4:0] DP_APPLY  = 5'd14;
   localparam logic [4:0] DP_SEQ    = 5'd15;
   localparam logic [4:0] DP_RESULT = 5'd16;

   typedef struct packed {
      logic [7:0]  entry_limit;
      logic [31:0] byte_budget;
      logic [31:0] time_to_live;
   } cfg_type;

   typedef struct packed {
      logic       start;
      logic [4:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_get;
      logic is_put;
      logic is_clear;
      logic found;
      logic expired;
      logic fits;
      logic seq_max;
      logic evict_need;
      logic free_ok;
      logic rec_valid;
      logic outer_last;
   } dp_stat_type;

endpackage

// ===== rtl/core/lbc_if.sv =====
// lbc_req_if and lbc_rsp_if: valid/ready channels for request and response items
// no dependencies
`timescale 1ns / 1ps

interface lbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] key_tag;
   logic [31:0] now;
   logic [31:0] item_bytes;
   logic [31:0] value_handle;

   modport source (output valid, cmd, key_tag, now, item_bytes, value_handle, input ready);
   modport sink (input valid, cmd, key_tag, now, item_bytes, value_handle, output ready);
endinterface

interface lbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] hit_value;
   logic        stored;

   modport source (output valid, hit, hit_value, stored, input ready);
   modport sink (input valid, hit, hit_value, stored, output ready);
endinterface

// ===== rtl/core/lru_ttl_byte_budget_cache.sv =====
// lru_ttl_byte_budget_cache: keyed cache with entry limit, byte budget and ttl
// depends on lbc_pkg, lbc_if, lbc_ram, lbc_dpath and lbc_ctrl
//
//   channel  dir  handshake             payload
//   req      in   valid/ready           cmd, key_tag, now, item_bytes, value_handle
//   rsp      out  valid/ready           hit, hit_value, stored
//   csr      in   apb psel/penable      entry_limit, byte_budget, time_to_live
//
// one item at a time; every table pass runs on the single ram read port
// get: one table pass, then on a hit a touch or a drop of the entry; clear: one pass
// put: (2 + evictions) passes; a recency renumber adds a rank scan per valid entry and an apply pass
// after reset a clearing pass runs before the first item is taken
// a result waits in the output register while the next item is accepted
`timescale 1ns / 1ps

module lru_ttl_byte_budget_cache #(
   parameter int CAPACITY   = 128,
   parameter int KEY_WIDTH  = 64,
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   lbc_req_if.sink     req,
   lbc_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import lbc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_ENTRY_LIMIT:  cfg_in.entry_limit  = pwdata[7:0];
            REG_BYTE_BUDGET:  cfg_in.byte_budget  = pwdata;
            REG_TIME_TO_LIVE: cfg_in.time_to_live = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ENTRY_LIMIT:  prdata = {24'd0, cfg_ff.entry_limit};
         REG_BYTE_BUDGET:  prdata = cfg_ff.byte_budget;
         REG_TIME_TO_LIVE: prdata = cfg_ff.time_to_live;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_limit  <= ENTRY_LIMIT_RESET;
         cfg_ff.byte_budget  <= BYTE_BUDGET_RESET;
         cfg_ff.time_to_live <= TIME_TO_LIVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lbc_dpath #(
      .CAPACITY   (CAPACITY),
      .KEY_WIDTH  (KEY_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg              (cfg_ff),
      .req_cmd          (req.cmd),
      .req_key_tag      (req.key_tag),
      .req_now          (req.now),
      .req_item_bytes   (req.item_bytes),
      .req_value_handle (req.value_handle),
      .out_hit          (rsp.hit),
      .out_hit_value    (rsp.hit_value),
      .out_stored       (rsp.stored)
   );

endmodule

// ===== rtl/core/lbc_ram.sv =====
// lbc_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/lbc_dpath.sv =====
// lbc_dpath: entry ram, scan pointers, counters and compares of the cache
// depends on lbc_pkg and lbc_ram
`timescale 1ns / 1ps

module lbc_dpath #(
   parameter int CAPACITY   = 128,
   parameter int KEY_WIDTH  = 64,
   parameter int TIME_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbc_pkg::dp_cmd_type  cmd,
   output lbc_pkg::dp_stat_type stat,
   input  lbc_pkg::cfg_type     cfg,
   input  logic [1:0]           req_cmd,
   input  logic [63:0]          req_key_tag,
   input  logic [31:0]          req_now,
   input  logic [31:0]          req_item_bytes,
   input  logic [31:0]          req_value_handle,
   output logic                 out_hit,
   output logic [31:0]          out_hit_value,
   output logic                 out_stored
);

   import lbc_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   typedef struct packed {
      logic                  valid;
      logic [KEY_WIDTH-1:0]  key;
      logic [31:0]           value;
      logic [TIME_WIDTH-1:0] ins;
      logic [31:0]           size;
      logic [31:0]           lu;
      logic [IW-1:0]         rank;
   } rec_type;

   localparam int RECW = $bits(rec_type);

   logic [IW:0]           issue_ff, issue_in;
   logic                  pv_ff, pv_in;
   logic [IW-1:0]         pidx_ff, pidx_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [31:0]           bytes_ff, bytes_in;
   logic [31:0]           handle_ff, handle_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           used_ff, used_in;
   logic [31:0]           seq_ff, seq_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         fidx_ff, fidx_in;
   rec_type               hold_ff, hold_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IW-1:0]         free_idx_ff, free_idx_in;
   logic                  best_ok_ff, best_ok_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   logic [31:0]           best_lu_ff, best_lu_in;
   logic [31:0]           best_size_ff, best_size_in;
   logic [IW:0]           rank_i_ff, rank_i_in;
   logic [IW-1:0]         rank_cnt_ff, rank_cnt_in;
   rec_type               rhold_ff, rhold_in;
   logic                  res_hit_ff, res_hit_in;
   logic [31:0]           res_value_ff, res_value_in;
   logic                  res_stored_ff, res_stored_in;
   logic                  out_hit_ff, out_hit_in;
   logic [31:0]           out_value_ff, out_value_in;
   logic                  out_stored_ff, out_stored_in;

   logic                  we;
   logic [IW-1:0]         waddr, raddr;
   rec_type               wdata, rd;
   logic [RECW-1:0]       rdata;
   logic [TIME_WIDTH-1:0] ttl_t;
   logic [CMPW-1:0]       lim_me, limit;
   logic                  rd_exp;

   lbc_ram #(.WIDTH(RECW), .DEPTH(CAPACITY)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   function automatic logic expired_f(input logic [TIME_WIDTH-1:0] ins);
      logic [TIME_WIDTH-1:0] age;
      age = now_ff - ins;
      return age >= ttl_t;
   endfunction

   assign rd     = rec_type'(rdata);
   assign ttl_t  = TIME_WIDTH'(cfg.time_to_live);
   assign lim_me = CMPW'(cfg.entry_limit);
   assign limit  = (lim_me > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : lim_me;
   assign rd_exp = expired_f(rd.ins);
   assign raddr  = (cmd.op == DP_RRD) ? rank_i_ff[IW-1:0] : issue_ff[IW-1:0];

   always_comb begin
      stat.scan_done  = (issue_ff == (IW+1)'(CAPACITY)) && !pv_ff;
      stat.is_get     = (cmd_ff == CMD_GET);
      stat.is_put     = (cmd_ff == CMD_PUT);
      stat.is_clear   = (cmd_ff == CMD_CLEAR);
      stat.found      = found_ff;
      stat.expired    = expired_f(hold_ff.ins);
      stat.fits       = (cfg.entry_limit != 8'd0) && (cfg.time_to_live != 32'd0)
                        && (bytes_ff <= cfg.byte_budget);
      stat.seq_max    = (seq_ff == 32'hFFFF_FFFF);
      stat.evict_need = (count_ff != CW'(0)) && ((CMPW'(count_ff) >= limit)
                        || ({1'b0, used_ff} + {1'b0, bytes_ff} > {1'b0, cfg.byte_budget}));
      stat.free_ok    = free_ok_ff;
      stat.rec_valid  = rd.valid;
      stat.outer_last = (rank_i_ff == (IW+1)'(CAPACITY - 1));
   end

   always_comb begin
      we    = 1'b0;
      waddr = pidx_ff;
      wdata = '0;
      unique case (cmd.op)
         DP_FIND: begin
            if (pv_ff && rd.valid && rd.key == key_ff && cmd_ff == CMD_PUT) begin
               we = 1'b1;
            end
         end
         DP_EXPIRE: begin
            if (pv_ff && rd.valid && rd_exp) begin
               we = 1'b1;
            end
         end
         DP_LDROP: begin
            we    = 1'b1;
            waddr = best_idx_ff;
         end
         DP_DROP: begin
            we    = 1'b1;
            waddr = fidx_ff;
         end
         DP_TOUCH: begin
            we       = 1'b1;
            waddr    = fidx_ff;
            wdata    = hold_ff;
            wdata.lu = seq_ff;
         end
         DP_INSERT: begin
            we    = free_ok_ff;
            waddr = free_idx_ff;
            wdata = '{valid: 1'b1, key: key_ff, value: handle_ff, ins: now_ff,
                      size: bytes_ff, lu: seq_ff, rank: '0};
         end
         DP_RWR: begin
            we         = rhold_ff.valid;
            waddr      = rank_i_ff[IW-1:0];
            wdata      = rhold_ff;
            wdata.rank = rank_cnt_ff;
         end
         DP_APPLY: begin
            we       = pv_ff && rd.valid;
            wdata    = rd;
            wdata.lu = 32'(rd.rank);
         end
         DP_CLEAR: begin
            we    = (issue_ff != (IW+1)'(CAPACITY));
            waddr = issue_ff[IW-1:0];
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_comb begin
      issue_in      = issue_ff;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      bytes_in      = bytes_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      seq_in        = seq_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      hold_in       = hold_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      best_ok_in    = best_ok_ff;
      best_idx_in   = best_idx_ff;
      best_lu_in    = best_lu_ff;
      best_size_in  = best_size_ff;
      rank_i_in     = rank_i_ff;
      rank_cnt_in   = rank_cnt_ff;
      rhold_in      = rhold_ff;
      res_hit_in    = res_hit_ff;
      res_value_in  = res_value_ff;
      res_stored_in = res_stored_ff;
      out_hit_in    = out_hit_ff;
      out_value_in  = out_value_ff;
      out_stored_in = out_stored_ff;

      // the held record is taken whether or not the rank scan starts
      if (cmd.op == DP_RHOLD) begin
         rhold_in = rd;
      end

      if (cmd.start) begin
         issue_in    = '0;
         pv_in       = 1'b0;
         best_ok_in  = 1'b0;
         rank_cnt_in = '0;
      end else begin
         if (cmd.op == DP_FIND || cmd.op == DP_EXPIRE || cmd.op == DP_LRU
             || cmd.op == DP_RSCAN || cmd.op == DP_APPLY) begin
            if (issue_ff != (IW+1)'(CAPACITY)) begin
               issue_in = issue_ff + (IW+1)'(1);
               pv_in    = 1'b1;
               pidx_in  = issue_ff[IW-1:0];
            end
         end
         unique case (cmd.op)
            DP_LOAD: begin
               cmd_in        = req_cmd;
               key_in        = KEY_WIDTH'(req_key_tag);
               now_in        = TIME_WIDTH'(req_now);
               bytes_in      = req_item_bytes;
               handle_in     = req_value_handle;
               found_in      = 1'b0;
               free_ok_in    = 1'b0;
               rank_i_in     = '0;
               res_hit_in    = 1'b0;
               res_value_in  = '0;
               res_stored_in = 1'b0;
            end
            DP_CLEAR: begin
               if (issue_ff != (IW+1)'(CAPACITY)) begin
                  issue_in = issue_ff + (IW+1)'(1);
               end
               count_in = '0;
               used_in  = '0;
               seq_in   = '0;
            end
            DP_FIND: begin
               if (pv_ff && rd.valid && rd.key == key_ff) begin
                  found_in = 1'b1;
                  fidx_in  = pidx_ff;
                  hold_in  = rd;
                  if (cmd_ff == CMD_PUT) begin
                     count_in = count_ff - CW'(1);
                     used_in  = used_ff - rd.size;
                  end
               end
            end
            DP_EXPIRE: begin
               if (pv_ff) begin
                  if (rd.valid && rd_exp) begin
                     count_in = count_ff - CW'(1);
                     used_in  = used_ff - rd.size;
                  end
                  if ((!rd.valid || rd_exp) && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pidx_ff;
                  end
               end
            end
            DP_LRU: begin
               if (pv_ff && rd.valid && (!best_ok_ff || rd.lu < best_lu_ff)) begin
                  best_ok_in   = 1'b1;
                  best_idx_in  = pidx_ff;
                  best_lu_in   = rd.lu;
                  best_size_in = rd.size;
               end
            end
            DP_LDROP: begin
               count_in = count_ff - CW'(1);
               used_in  = used_ff - best_size_ff;
               if (!free_ok_ff || best_idx_ff < free_idx_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = best_idx_ff;
               end
            end
            DP_DROP: begin
               count_in = count_ff - CW'(1);
               used_in  = used_ff - hold_ff.size;
            end
            DP_TOUCH: begin
               seq_in       = seq_ff + 32'd1;
               res_hit_in   = 1'b1;
               res_value_in = hold_ff.value;
            end
            DP_INSERT: begin
               if (free_ok_ff) begin
                  count_in      = count_ff + CW'(1);
                  used_in       = used_ff + bytes_ff;
                  seq_in        = seq_ff + 32'd1;
                  res_stored_in = 1'b1;
               end
            end
            DP_RSCAN: begin
               if (pv_ff && rd.valid && rd.lu < rhold_ff.lu) begin
                  rank_cnt_in = rank_cnt_ff + IW'(1);
               end
            end
            DP_RWR: begin
               rank_i_in = rank_i_ff + (IW+1)'(1);
            end
            DP_SEQ: begin
               seq_in = 32'(count_ff);
            end
            DP_RESULT: begin
               out_hit_in    = res_hit_ff;
               out_value_in  = res_value_ff;
               out_stored_in = res_stored_ff;
            end
            default: begin
               pidx_in = pidx_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= '0;
         pv_ff      <= 1'b0;
         count_ff   <= '0;
         used_ff    <= '0;
         seq_ff     <= '0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         best_ok_ff <= 1'b0;
         rank_i_ff  <= '0;
         cmd_ff     <= CMD_GET;
      end else begin
         issue_ff   <= issue_in;
         pv_ff      <= pv_in;
         count_ff   <= count_in;
         used_ff    <= used_in;
         seq_ff     <= seq_in;
         found_ff   <= found_in;
         free_ok_ff <= free_ok_in;
         best_ok_ff <= best_ok_in;
         rank_i_ff  <= rank_i_in;
         cmd_ff     <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      bytes_ff      <= bytes_in;
      handle_ff     <= handle_in;
      fidx_ff       <= fidx_in;
      hold_ff       <= hold_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_lu_ff    <= best_lu_in;
      best_size_ff  <= best_size_in;
      rank_cnt_ff   <= rank_cnt_in;
      rhold_ff      <= rhold_in;
      res_hit_ff    <= res_hit_in;
      res_value_ff  <= res_value_in;
      res_stored_ff <= res_stored_in;
      out_hit_ff    <= out_hit_in;
      out_value_ff  <= out_value_in;
      out_stored_ff <= out_stored_in;
   end

   assign out_hit       = out_hit_ff;
   assign out_hit_value = out_value_ff;
   assign out_stored    = out_stored_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("live count above capacity");

   a_start_rewinds: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (issue_ff == '0) && !pv_ff)
      else $error("scan start did not rewind the pointer");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_INSERT && !cmd.start && free_ok_ff) |=>
      count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not add one live entry");

endmodule

// ===== rtl/core/lbc_ctrl.sv =====
// lbc_ctrl: sequencer of the cache, issues datapath commands per item
// depends on lbc_pkg
`timescale 1ns / 1ps

module lbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lbc_pkg::dp_stat_type stat,
   output lbc_pkg::dp_cmd_type  cmd
);

   import lbc_pkg::*;

   localparam logic [4:0] S_RCLR   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_DISP   = 5'd2;
   localparam logic [4:0] S_CLR    = 5'd3;
   localparam logic [4:0] S_FIND   = 5'd4;
   localparam logic [4:0] S_GCHK   = 5'd5;
   localparam logic [4:0] S_DROP   = 5'd6;
   localparam logic [4:0] S_TOUCH  = 5'd7;
   localparam logic [4:0] S_EXP    = 5'd8;
   localparam logic [4:0] S_EVCHK  = 5'd9;
   localparam logic [4:0] S_LRU    = 5'd10;
   localparam logic [4:0] S_LDROP  = 5'd11;
   localparam logic [4:0] S_INSCHK = 5'd12;
   localparam logic [4:0] S_INS    = 5'd13;
   localparam logic [4:0] S_RRD    = 5'd14;
   localparam logic [4:0] S_RHOLD  = 5'd15;
   localparam logic [4:0] S_RSCAN  = 5'd16;
   localparam logic [4:0] S_RWR    = 5'd17;
   localparam logic [4:0] S_APPLY  = 5'd18;
   localparam logic [4:0] S_SEQ    = 5'd19;
   localparam logic [4:0] S_DONE   = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.start    = 1'b0;
      cmd.op       = DP_NONE;
      unique case (state_ff)
         S_RCLR: begin
            cmd.op = DP_CLEAR;
            if (stat.scan_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.is_get || stat.is_put) begin
               cmd.start = 1'b1;
               state_in  = S_FIND;
            end else if (stat.is_clear) begin
               cmd.start = 1'b1;
               state_in  = S_CLR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLR: begin
            cmd.op = DP_CLEAR;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_FIND: begin
            cmd.op = DP_FIND;
            if (stat.scan_done) begin
               if (stat.is_get) begin
                  state_in = stat.found ? S_GCHK : S_DONE;
               end else if (stat.fits) begin
                  cmd.start = 1'b1;
                  state_in  = S_EXP;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_GCHK: begin
            if (stat.expired) begin
               state_in = S_DROP;
            end else begin
               state_in = stat.seq_max ? S_RRD : S_TOUCH;
            end
         end
         S_DROP: begin
            cmd.op   = DP_DROP;
            state_in = S_DONE;
         end
         S_TOUCH: begin
            cmd.op   = DP_TOUCH;
            state_in = S_DONE;
         end
         S_EXP: begin
            cmd.op = DP_EXPIRE;
            if (stat.scan_done) begin
               state_in = S_EVCHK;
            end
         end
         S_EVCHK: begin
            if (stat.evict_need) begin
               cmd.start = 1'b1;
               state_in  = S_LRU;
            end else begin
               state_in = S_INSCHK;
            end
         end
         S_LRU: begin
            cmd.op = DP_LRU;
            if (stat.scan_done) begin
               state_in = S_LDROP;
            end
         end
         S_LDROP: begin
            cmd.op   = DP_LDROP;
            state_in = S_EVCHK;
         end
         S_INSCHK: begin
            if (!stat.free_ok) begin
               state_in = S_DONE;
            end else begin
               state_in = stat.seq_max ? S_RRD : S_INS;
            end
         end
         S_INS: begin
            cmd.op   = DP_INSERT;
            state_in = S_DONE;
         end
         S_RRD: begin
            cmd.op   = DP_RRD;
            state_in = S_RHOLD;
         end
         S_RHOLD: begin
            cmd.op = DP_RHOLD;
            if (stat.rec_valid) begin
               cmd.start = 1'b1;
               state_in  = S_RSCAN;
            end else begin
               state_in = S_RWR;
            end
         end
         S_RSCAN: begin
            cmd.op = DP_RSCAN;
            if (stat.scan_done) begin
               state_in = S_RWR;
            end
         end
         S_RWR: begin
            cmd.op = DP_RWR;
            if (stat.outer_last) begin
               state_in = S_APPLY;
            end else begin
               state_in = S_RRD;
            end
         end
         S_APPLY: begin
            cmd.op = DP_APPLY;
            if (stat.scan_done) begin
               state_in = S_SEQ;
            end
         end
         S_SEQ: begin
            cmd.op   = DP_SEQ;
            state_in = stat.is_put ? S_INS : S_TOUCH;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // the apply scan is rewound on its way in from the last rank write
      if (state_ff == S_RWR && stat.outer_last) begin
         cmd.start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RCLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> cmd.op == DP_LOAD)
      else $error("accepted item not loaded");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == S_DONE)
      else $error("result overwritten before it was taken");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DISP)
      else $error("accepted item did not start");

endmodule
